// ===== design/aes_sb_pkg.sv =====
// Package for the AES S-box block: field constants, degree search and affine map.
// Used by aes_sbox_gf_inverse_affine_top; depends on nothing else.
`timescale 1ns / 1ps

package aes_sb_pkg;

  localparam int BYTE_W = 8;
  localparam int POLY_W = BYTE_W + 1;
  localparam int DEG_W  = 4;

  localparam logic [POLY_W-1:0] FIELD_POLY = 9'h11B;
  localparam logic [BYTE_W-1:0] AFFINE_C   = 8'h63;

  typedef logic [POLY_W-1:0] poly_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [DEG_W-1:0]  deg_t;

  localparam byte_t AFFINE_ROWS [BYTE_W] = '{
    8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C, 8'hF8
  };

  // Degree of a polynomial, zero for the zero polynomial.
  function automatic deg_t top_bit(input poly_t v);
    deg_t idx;
    idx = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (v[i]) idx = DEG_W'(i);
    end
    return idx;
  endfunction

  function automatic byte_t affine(input byte_t b);
    byte_t res;
    res = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      res[i] = ^(AFFINE_ROWS[i] & b);
    end
    return res ^ AFFINE_C;
  endfunction

endpackage

// ===== design/aes_sbox_gf_inverse_affine_top.sv =====
// AES forward S-box: GF(2^8) inverse by a one-step-per-cycle Euclid loop, then affine map.
// Depends on aes_sb_pkg.
`timescale 1ns / 1ps

// One request at a time. After a byte is accepted, the Euclid loop does one
// shift-and-reduce or one swap per cycle on the remainder pair; inputs 0 and 1
// start at the finish and need no step, while for other bytes the run length is
// set by the number of reduce and swap steps. A finished loop stays busy until
// the output register is free; in_ready is high whenever busy is low, so a new
// byte may enter while the previous result waits in the output register.
module aes_sbox_gf_inverse_affine_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aes_sb_pkg::byte_t    in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aes_sb_pkg::byte_t    sbox_value,
  output aes_sb_pkg::byte_t    inverse_value
);
  import aes_sb_pkg::*;

  logic  busy;
  poly_t r0, r1, x0, x1;
  deg_t  deg0, deg1, shift;
  logic  done0, done1, out_free, in_take;
  byte_t inv_res;

  assign in_ready = !busy;
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign deg0  = top_bit(r0);
  assign deg1  = top_bit(r1);
  assign shift = deg0 - deg1;
  assign done1 = (r1 == poly_t'(1));
  assign done0 = (r0 == poly_t'(1));
  assign inv_res = done1 ? x1[BYTE_W-1:0] : x0[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && (done0 || done1)) begin
        if (out_free) begin
          busy      <= 1'b0;
          out_valid <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_take) busy <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r0 <= FIELD_POLY;
      x0 <= '0;
      // zero has no inverse: start at the finish with a zero coefficient
      if (in_byte == '0) begin
        r1 <= poly_t'(1);
        x1 <= '0;
      end else begin
        r1 <= {1'b0, in_byte};
        x1 <= poly_t'(1);
      end
    end else if (busy && !(done0 || done1)) begin
      if (deg0 < deg1) begin
        r0 <= r1;
        r1 <= r0;
        x0 <= x1;
        x1 <= x0;
      end else begin
        r0 <= r0 ^ (r1 << shift);
        x0 <= x0 ^ (x1 << shift);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && (done0 || done1) && out_free) begin
      inverse_value <= inv_res;
      sbox_value    <= affine(inv_res);
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("input taken while loop running");

  a_nonzero_rem: assert property (@(posedge clk) disable iff (rst)
    busy |-> (r0 != '0 && r1 != '0))
    else $error("remainder reached zero before one");

  a_start_from_take: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(in_valid && in_ready))
    else $error("loop started without a request");

endmodule
